/* rtl/cdsd_pkg.sv */
package cdsd_pkg;

   // command field
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_FILL    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SHUFFLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEAL    = 2'd2;

   // fixed field widths
   localparam int RND_W  = 32;
   localparam int CARD_W = 6;
   localparam int LEFT_W = 8;
   localparam int DECK_W = 3;

   // status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

endpackage

/* rtl/card_deck_shuffle_and_deal.sv */
// Card deck store with fill, single-swap shuffle step and deal. A command is
// taken when start is high and busy is low; its one result appears for a
// single cycle with rsp_strobe and cannot be held off by the receiver.
// A shuffle step is paced by the 32-step bit-serial modulo unit plus two reads
// and two writes on the deck store, which has one read and one write port.
// A fill writes one entry per cycle; a shuffle of a deck of 0 or 1 cards or
// an unknown command answers in the cycle after it is taken, without raising
// busy. The store holds CARDS_PER_DECK * MAX_DECKS entries; num_decks may
// only be written while busy is low.
module card_deck_shuffle_and_deal #(
   parameter int CARDS_PER_DECK = 52,
   parameter int MAX_DECKS      = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cdsd_pkg::CMD_W-1:0]      req_command,
   input  logic [cdsd_pkg::RND_W-1:0]      req_random_value,
   output logic                            rsp_strobe,
   output logic                            rsp_status,
   output logic [cdsd_pkg::CARD_W-1:0]     rsp_card,
   output logic [cdsd_pkg::LEFT_W-1:0]     rsp_cards_left,
   output logic                            rsp_pass_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cdsd_pkg::DECK_W-1:0]     csr_num_decks
);
   import cdsd_pkg::*;

   localparam int STORE_DEPTH = CARDS_PER_DECK * MAX_DECKS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FILL = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_RDJ  = 3'd3;
   localparam logic [2:0] S_RDC  = 3'd4;
   localparam logic [2:0] S_WRJ  = 3'd5;
   localparam logic [2:0] S_WRC  = 3'd6;
   localparam logic [2:0] S_DEAL = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   cursor_ff, cursor_in;
   logic [DECK_W-1:0]   num_decks_ff;
   logic [CNT_W-1:0]    fill_idx_ff, fill_idx_in;
   logic [CNT_W-1:0]    fill_total_ff, fill_total_in;
   logic [CARD_W-1:0]   fill_card_ff, fill_card_in;
   logic [ADDR_W-1:0]   j_ff, j_in;
   logic [CARD_W-1:0]   tj_ff, tj_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [CARD_W-1:0]   rsp_card_ff, rsp_card_in;
   logic [LEFT_W-1:0]   rsp_left_ff;
   logic                rsp_done_ff, rsp_done_in;
   logic [CNT_W+LEFT_W-1:0] left_ext;

   logic [DECK_W:0]     decks_sat;
   logic [CNT_W-1:0]    total_cards;
   logic [ADDR_W-1:0]   top_addr;
   logic [ADDR_W-1:0]   cur_sel;

   logic                mod_start;
   logic                mod_done;
   logic [CNT_W-1:0]    mod_divisor;
   logic [CNT_W-1:0]    mod_rem;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CARD_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CARD_W-1:0]   rd_data;

   // saturate the deck count to what the store holds
   assign decks_sat = ({1'b0, num_decks_ff} > (DECK_W+1)'(MAX_DECKS)) ?
                      (DECK_W+1)'(MAX_DECKS) : {1'b0, num_decks_ff};
   assign total_cards = CNT_W'(int'(decks_sat) * CARDS_PER_DECK);

   assign top_addr    = ADDR_W'(count_ff - CNT_W'(1));
   // open a new pass from the top when no pass is running
   assign cur_sel     = (cursor_ff == '0) ? top_addr : cursor_ff;
   assign mod_divisor = CNT_W'(cur_sel) + CNT_W'(1);

   cdsd_mod_unit #(
      .DIV_W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_random_value),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   cdsd_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (state_ff)
         S_RDJ:   rd_addr = j_ff;
         S_RDC:   rd_addr = cursor_ff;
         default: rd_addr = top_addr;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      fill_idx_in    = fill_idx_ff;
      fill_total_in  = fill_total_ff;
      fill_card_in   = fill_card_ff;
      j_in           = j_ff;
      tj_in          = tj_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = STATUS_OK;
      rsp_card_in    = '0;
      rsp_done_in    = 1'b0;
      mod_start      = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = fill_idx_ff[ADDR_W-1:0];
      wr_data        = fill_card_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_command)
                  CMD_FILL: begin
                     fill_total_in = total_cards;
                     fill_idx_in   = '0;
                     fill_card_in  = '0;
                     cursor_in     = '0;
                     state_in      = S_FILL;
                  end
                  CMD_SHUFFLE: begin
                     if (cursor_ff == '0 && count_ff <= CNT_W'(1)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_done_in   = 1'b1;
                     end else begin
                        cursor_in = cur_sel;
                        mod_start = 1'b1;
                        state_in  = S_MOD;
                     end
                  end
                  CMD_DEAL: begin
                     cursor_in = '0;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // store read of the top entry is already under way
                        state_in = S_DEAL;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_FILL: begin
            if (fill_idx_ff == fill_total_ff) begin
               count_in      = fill_total_ff;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               wr_en       = 1'b1;
               fill_idx_in = fill_idx_ff + CNT_W'(1);
               if (fill_card_ff == CARD_W'(CARDS_PER_DECK - 1)) begin
                  fill_card_in = '0;
               end else begin
                  fill_card_in = fill_card_ff + CARD_W'(1);
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               j_in     = ADDR_W'(mod_rem);
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            state_in = S_RDC;
         end
         S_RDC: begin
            tj_in    = rd_data;
            state_in = S_WRJ;
         end
         S_WRJ: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff;
            wr_data  = rd_data;
            state_in = S_WRC;
         end
         S_WRC: begin
            wr_en         = 1'b1;
            wr_addr       = cursor_ff;
            wr_data       = tj_ff;
            cursor_in     = cursor_ff - ADDR_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_done_in   = (cursor_ff == ADDR_W'(1));
            state_in      = S_IDLE;
         end
         S_DEAL: begin
            rsp_card_in   = rd_data;
            count_in      = count_ff - CNT_W'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign left_ext = {{LEFT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         cursor_ff     <= '0;
         num_decks_ff  <= DECK_W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cursor_ff     <= cursor_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            num_decks_ff <= csr_num_decks;
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff   <= fill_idx_in;
      fill_total_ff <= fill_total_in;
      fill_card_ff  <= fill_card_in;
      j_ff          <= j_in;
      tj_ff         <= tj_in;
      rsp_status_ff <= rsp_status_in;
      rsp_card_ff   <= rsp_card_in;
      rsp_left_ff   <= left_ext[LEFT_W-1:0];
      rsp_done_ff   <= rsp_done_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_card       = rsp_card_ff;
   assign rsp_cards_left = rsp_left_ff;
   assign rsp_pass_done  = rsp_done_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= STORE_DEPTH)
      else $error("card count exceeds store depth");

   a_cursor_below_top: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == '0 || cursor_ff < top_addr || cursor_ff == top_addr)
      else $error("shuffle cursor points past the top card");

   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD)
      else $error("modulo result outside of a shuffle step");

   a_fill_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_FILL |=> busy && !rsp_strobe)
      else $error("fill transfer did not start the sweep");

   a_empty_deal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STATUS_EMPTY |-> rsp_card == '0 && count_ff == '0)
      else $error("empty deal changed the deck");

endmodule

/* rtl/cdsd_mod_unit.sv */
module cdsd_mod_unit #(
   parameter int DIV_W = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cdsd_pkg::RND_W-1:0]     dividend,
   input  logic [DIV_W-1:0]               divisor,
   output logic                           done,
   output logic [DIV_W-1:0]               remainder
);
   import cdsd_pkg::*;

   localparam int STEP_W = $clog2(RND_W);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [RND_W-1:0]    dvd_ff, dvd_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W:0]      trial;

   // one restoring step per cycle, most significant dividend bit first
   assign trial = {rem_ff, dvd_ff[RND_W-1]};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         dvd_in    = dividend;
         div_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         dvd_in  = {dvd_ff[RND_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(RND_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/cdsd_store.sv */
module cdsd_store #(
   parameter int DEPTH  = 208,
   parameter int ADDR_W = 8
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [cdsd_pkg::CARD_W-1:0]     wr_data,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [cdsd_pkg::CARD_W-1:0]     rd_data
);
   import cdsd_pkg::*;

   logic [CARD_W-1:0] mem [DEPTH];
   logic [CARD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/card_deck_shuffle_and_deal_tb.sv */
module card_deck_shuffle_and_deal_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdsd_pkg::*;

   localparam int DECK_SIZE      = 52;
   localparam int MAX_DECKS      = 4;
   localparam int STORE_DEPTH    = DECK_SIZE * MAX_DECKS;
   localparam int ITEM_TARGET    = 1950;
   localparam int PHASE_COUNT    = 8;
   localparam int SETTLE_CYCLES  = 250;
   localparam int CYCLE_LIMIT    = 2_500_000;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef struct {
      logic [CMD_W-1:0] command;
      logic [RND_W-1:0] random_value;
   } deal_request_type;

   typedef struct {
      logic              status;
      logic [CARD_W-1:0] card;
      logic [LEFT_W-1:0] cards_left;
      logic              pass_done;
   } deal_result_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_command      = CMD_FILL;
   logic [RND_W-1:0]  req_random_value = '0;
   logic              rsp_strobe;
   logic              rsp_status;
   logic [CARD_W-1:0] rsp_card;
   logic [LEFT_W-1:0] rsp_cards_left;
   logic              rsp_pass_done;
   logic              csr_valid        = 1'b0;
   logic              csr_ready;
   logic [DECK_W-1:0] csr_num_decks    = '0;

   // deck state as the block should hold it
   logic [CARD_W-1:0] deck_cards [STORE_DEPTH];
   int unsigned       deck_count    = 0;
   int unsigned       swap_cursor   = 0;
   logic [DECK_W-1:0] decks_setting = 3'd1;

   deal_request_type pending_requests [$];
   deal_result_type  expected_results [$];

   int unsigned n_queued       = 0;
   int unsigned n_accepted     = 0;
   int unsigned n_items        = 0;
   int unsigned n_errors       = 0;
   int unsigned cycle_count    = 0;
   int unsigned gap_left       = 0;
   int unsigned sender_gap_max = 5;

   card_deck_shuffle_and_deal #(
      .CARDS_PER_DECK(DECK_SIZE),
      .MAX_DECKS     (MAX_DECKS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_random_value(req_random_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_card        (rsp_card),
      .rsp_cards_left  (rsp_cards_left),
      .rsp_pass_done   (rsp_pass_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_decks   (csr_num_decks)
   );

   always #4 clock = ~clock;

   task automatic note_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      n_errors++;
   endtask

   // apply one accepted command to the deck state and queue its result
   task automatic advance_deck_model(input logic [CMD_W-1:0] cmd,
                                     input logic [RND_W-1:0] rnd);
      deal_result_type   res;
      int unsigned       total;
      int unsigned       pick;
      logic [CARD_W-1:0] held;
      res.status    = STATUS_OK;
      res.card      = '0;
      res.pass_done = 1'b0;
      case (cmd)
         CMD_FILL: begin
            total = ((decks_setting > MAX_DECKS) ? MAX_DECKS : decks_setting) * DECK_SIZE;
            for (int i = 0; i < total; i++) deck_cards[i] = CARD_W'(i % DECK_SIZE);
            deck_count  = total;
            swap_cursor = 0;
         end
         CMD_SHUFFLE: begin
            if (swap_cursor == 0 && deck_count <= 1) begin
               res.pass_done = 1'b1;
            end else begin
               if (swap_cursor == 0) swap_cursor = deck_count - 1;
               pick = rnd % (swap_cursor + 1);
               held                     = deck_cards[pick];
               deck_cards[pick]         = deck_cards[swap_cursor];
               deck_cards[swap_cursor]  = held;
               swap_cursor--;
               res.pass_done = (swap_cursor == 0);
            end
         end
         CMD_DEAL: begin
            swap_cursor = 0;
            if (deck_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.card = deck_cards[deck_count - 1];
               deck_count--;
            end
         end
         default: ;
      endcase
      res.cards_left = LEFT_W'(deck_count);
      expected_results.push_back(res);
   endtask

   always @(posedge clock) begin : request_driver
      deal_request_type nxt;
      logic             slot_free;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         slot_free = !start;
         if (start && !busy) begin
            advance_deck_model(req_command, req_random_value);
            n_accepted++;
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start    <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               nxt = pending_requests.pop_front();
               req_command      <= nxt.command;
               req_random_value <= nxt.random_value;
               start            <= 1'b1;
               gap_left         <= $urandom_range(0, sender_gap_max);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      deal_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            note_mismatch("result with no command outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status %0b, want %0b", rsp_status, want.status));
            if (rsp_card !== want.card)
               note_mismatch($sformatf("card %0d, want %0d", rsp_card, want.card));
            if (rsp_cards_left !== want.cards_left)
               note_mismatch($sformatf("cards_left %0d, want %0d",
                                       rsp_cards_left, want.cards_left));
            if (rsp_pass_done !== want.pass_done)
               note_mismatch($sformatf("pass_done %0b, want %0b",
                                       rsp_pass_done, want.pass_done));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [RND_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return RND_W'($urandom_range(0, 300));
         default: return RND_W'($urandom);
      endcase
   endfunction

   task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [RND_W-1:0] rnd);
      deal_request_type item;
      item.command      = cmd;
      item.random_value = rnd;
      pending_requests.push_back(item);
      n_queued++;
      if (cmd != CMD_UNKNOWN) n_items++;
   endtask

   task automatic wait_accepted();
      while (n_accepted != n_queued) @(posedge clock);
   endtask

   task automatic drain_results();
      wait_accepted();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // write only with the block idle: every result back first
   task automatic write_num_decks(input logic [DECK_W-1:0] value);
      drain_results();
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_num_decks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      decks_setting = value;
   endtask

   initial begin : stimulus
      logic [DECK_W-1:0] phase_decks [PHASE_COUNT];
      int unsigned       phase_target;
      int unsigned       left;
      int unsigned       keep;
      int unsigned       trim;
      int unsigned       steps;
      int unsigned       room;
      phase_decks = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_num_decks(3'd1);
      queue_request(CMD_DEAL, '0);                // empty deck
      queue_request(CMD_SHUFFLE, 32'h1234_5678);  // nothing to shuffle
      queue_request(CMD_UNKNOWN, '1);
      queue_request(CMD_FILL, '1);
      queue_request(CMD_DEAL, '0);
      queue_request(CMD_SHUFFLE, '0);
      queue_request(CMD_SHUFFLE, '1);
      queue_request(CMD_SHUFFLE, 32'h8000_0000);
      queue_request(CMD_DEAL, '1);                // abandons the open pass
      queue_request(CMD_SHUFFLE, 32'h0000_0001);
      queue_request(CMD_SHUFFLE, 32'h7FFF_FFFF);
      queue_request(CMD_FILL, '0);                // abandons the open pass
      queue_request(CMD_UNKNOWN, '0);
      queue_request(CMD_DEAL, '0);

      foreach (phase_decks[p]) begin
         write_num_decks(phase_decks[p]);
         phase_target = n_items + ITEM_TARGET / PHASE_COUNT;
         while (n_items < phase_target) begin
            sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            case ($urandom_range(0, 9))
               0, 1: begin
                  // broken pass: cut short by a deal or a fill, or only interrupted by a stray command
                  if ($urandom_range(0, 1)) queue_request(CMD_FILL, rand_word());
                  repeat ($urandom_range(1, 20)) queue_request(CMD_SHUFFLE, rand_word());
                  case ($urandom_range(0, 2))
                     0:       queue_request(CMD_DEAL, rand_word());
                     1:       queue_request(CMD_FILL, rand_word());
                     default: queue_request(CMD_UNKNOWN, rand_word());
                  endcase
                  repeat ($urandom_range(0, 5)) queue_request(CMD_SHUFFLE, rand_word());
               end
               2: begin
                  repeat ($urandom_range(1, 15))
                     queue_request(CMD_W'($urandom_range(0, 3)), rand_word());
               end
               default: begin
                  // fill, trim, one full pass (sometimes one step more), then deal
                  queue_request(CMD_FILL, rand_word());
                  wait_accepted();
                  left = deck_count;
                  if (left <= 2 * DECK_SIZE && $urandom_range(0, 9) < 3) begin
                     keep = $urandom_range(0, 3);
                     trim = (left > keep) ? left - keep : 0;
                  end else begin
                     trim = $urandom_range(0, 6);
                     if (trim > left) trim = left;
                  end
                  repeat (trim) queue_request(CMD_DEAL, rand_word());
                  left  = left - trim;
                  steps = (left <= 1) ? 1 : left - 1;
                  if ($urandom_range(0, 9) < 3) steps++;
                  // cut the pass short where the phase is nearly used up
                  room = (phase_target > n_items) ? phase_target - n_items : 1;
                  if (steps > room) steps = room;
                  repeat (steps) queue_request(CMD_SHUFFLE, rand_word());
                  if (left <= 60 && $urandom_range(0, 4) == 0)
                     repeat (left + 1) queue_request(CMD_DEAL, rand_word());
                  else
                     repeat ($urandom_range(1, 10)) queue_request(CMD_DEAL, rand_word());
               end
            endcase
            if ($urandom_range(0, 9) == 0) drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
